FILE: hw/rtl/hse_pkg.sv
// Package with the sequencer state type for the heap sort engine.
package hse_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_SIFT_RD,
    ST_SIFT_WAIT,
    ST_SIFT_CMP,
    ST_SIFT_WR,
    ST_EXTRACT,
    ST_EX_WAIT,
    ST_EX_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } hse_state_t;
endpackage

FILE: hw/rtl/heap_sort_engine.sv
// Heap sort engine: loads a batch of keys, heapsorts them in a memory, then streams them out.
// Load: one key beat per cycle; a beat marked last starts the sort.
// Sort: each sift level issues and collects the parent and in-range child reads through the
// one read port, waits, compares, and when a swap is needed makes two swap writes; each root
// extraction first reads the root and the heap end and swaps them with two writes.
// Emit: each result beat is read from the key memory, registered, and held until taken.
// Reset (rst_n, synchronous, active low) clears the count, drop flag, order and sequencer.
module heap_sort_engine #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sorted_key,
  output logic        out_last_out,
  output logic        out_keys_dropped,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import hse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = AW + 2;

  hse_state_t state_r, state_nxt;

  // Key memory, one read and one write port.
  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  logic          order_r;
  logic          desc_r, desc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] size_r, size_nxt;    // heap size for current sift
  logic [CW-1:0] bld_r, bld_nxt;      // build index, one above next node
  logic [CW-1:0] ext_r, ext_nxt;      // extraction end index
  logic          phase_r, phase_nxt;  // 0 build, 1 extract
  logic [AW-1:0] node_r, node_nxt;
  logic [1:0]    rd_r, rd_nxt;        // reads issued: parent, left, right
  logic [1:0]    got_r, got_nxt;
  logic [KEY_WIDTH-1:0] pk_r, pk_nxt, lk_r, lk_nxt, rk_r, rk_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [KEY_WIDTH-1:0] topk_r, topk_nxt;
  logic          wsec_r, wsec_nxt;
  logic [CW-1:0] emi_r, emi_nxt;
  logic [31:0]   okey_r, okey_nxt;
  logic          olast_r, olast_nxt;

  logic [NW-1:0] lc, rc;
  logic          lc_in, rc_in;
  assign lc    = {2'b00, node_r} * NW'(2) + NW'(1);
  assign rc    = lc + NW'(1);
  assign lc_in = lc < NW'(size_r);
  assign rc_in = rc < NW'(size_r);

  function automatic logic after(input logic d, input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b);
    after = d ? (a < b) : (a > b);
  endfunction

  // Order register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;  size_r <= size_nxt;  bld_r <= bld_nxt;
    ext_r <= ext_nxt;    phase_r <= phase_nxt; node_r <= node_nxt;
    rd_r <= rd_nxt;      got_r <= got_nxt;    pk_r <= pk_nxt;
    lk_r <= lk_nxt;      rk_r <= rk_nxt;      top_r <= top_nxt;
    topk_r <= topk_nxt;  wsec_r <= wsec_nxt;  emi_r <= emi_nxt;
    okey_r <= okey_nxt;  olast_r <= olast_nxt;
  end

  // Next state and memory control.
  always_comb begin
    logic [AW-1:0]        t;
    logic [KEY_WIDTH-1:0] tk;
    state_nxt = state_r;  cnt_nxt = cnt_r;   drop_nxt = drop_r;
    desc_nxt = desc_r;    size_nxt = size_r; bld_nxt = bld_r;
    ext_nxt = ext_r;      phase_nxt = phase_r; node_nxt = node_r;
    rd_nxt = rd_r;        got_nxt = got_r;   pk_nxt = pk_r;
    lk_nxt = lk_r;        rk_nxt = rk_r;     top_nxt = top_r;
    topk_nxt = topk_r;    wsec_nxt = wsec_r; emi_nxt = emi_r;
    okey_nxt = okey_r;    olast_nxt = olast_r;
    we = 1'b0; waddr = '0; wdata = KEY_WIDTH'(in_key_in); raddr = '0;
    in_ready = 1'b0; out_valid = 1'b0;
    t = node_r; tk = pk_r;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CW'(DEPTH)) begin
            we = 1'b1; waddr = cnt_r[AW-1:0]; cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_in) begin
            desc_nxt  = order_r;
            phase_nxt = 1'b0;
            bld_nxt   = ((cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r) >> 1;
            size_nxt  = (cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r;
            ext_nxt   = size_nxt - CW'(1);
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        if (bld_r == '0) begin
          phase_nxt = 1'b1; state_nxt = ST_EXTRACT;
        end else begin
          node_nxt = AW'(bld_r - CW'(1)); bld_nxt = bld_r - CW'(1);
          rd_nxt = 2'd0; got_nxt = 2'd0; state_nxt = ST_SIFT_RD;
        end
      end
      // Read parent, then children in range; read data is registered and arrives in the cycle after its address.
      ST_SIFT_RD: begin
        if (got_r == 2'd1) pk_nxt = rdata_r;
        if (got_r == 2'd2) lk_nxt = rdata_r;
        if (got_r == 2'd3) rk_nxt = rdata_r;
        if (rd_r == 2'd0) begin
          raddr = node_r; rd_nxt = 2'd1; got_nxt = 2'd1;
        end else if (rd_r == 2'd1 && lc_in) begin
          raddr = lc[AW-1:0]; rd_nxt = 2'd2; got_nxt = 2'd2;
        end else if (rd_r == 2'd2 && rc_in) begin
          raddr = rc[AW-1:0]; rd_nxt = 2'd3; got_nxt = 2'd3;
        end else begin
          // All reads collected; nothing is left in flight.
          got_nxt = 2'd0; state_nxt = ST_SIFT_WAIT;
        end
        if (rd_r == 2'd1 && !lc_in) state_nxt = ST_SIFT_WAIT;
      end
      ST_SIFT_WAIT: begin
        if (got_r == 2'd1) pk_nxt = rdata_r;
        if (got_r == 2'd2) lk_nxt = rdata_r;
        if (got_r == 2'd3) rk_nxt = rdata_r;
        state_nxt = ST_SIFT_CMP;
      end
      ST_SIFT_CMP: begin
        if (lc_in && after(desc_r, lk_r, tk)) begin t = lc[AW-1:0]; tk = lk_r; end
        if (rc_in && after(desc_r, rk_r, tk)) begin t = rc[AW-1:0]; tk = rk_r; end
        top_nxt = t; topk_nxt = tk; wsec_nxt = 1'b0;
        if (t == node_r) begin
          state_nxt = phase_r ? ST_EXTRACT : ST_BUILD;
        end else begin
          state_nxt = ST_SIFT_WR;
        end
      end
      // Swap parent and the chosen child (larger when ascending, smaller when descending) with two writes.
      ST_SIFT_WR: begin
        we = 1'b1;
        if (!wsec_r) begin
          waddr = node_r; wdata = topk_r; wsec_nxt = 1'b1;
        end else begin
          waddr = top_r; wdata = pk_r; node_nxt = top_r;
          rd_nxt = 2'd0; got_nxt = 2'd0; state_nxt = ST_SIFT_RD;
        end
      end
      // Swap root with end of heap, then sift the shrunken heap.
      ST_EXTRACT: begin
        if (ext_r == '0) begin
          emi_nxt = '0; state_nxt = ST_EMIT_RD;
        end else begin
          raddr = '0; state_nxt = ST_EX_WAIT;
        end
      end
      ST_EX_WAIT: begin
        pk_nxt = rdata_r; raddr = ext_r[AW-1:0]; wsec_nxt = 1'b0;
        state_nxt = ST_EX_WR;
      end
      ST_EX_WR: begin
        we = 1'b1;
        if (!wsec_r) begin
          waddr = '0; wdata = rdata_r; wsec_nxt = 1'b1;
        end else begin
          waddr = ext_r[AW-1:0]; wdata = pk_r;
          size_nxt = ext_r; ext_nxt = ext_r - CW'(1); node_nxt = '0;
          rd_nxt = 2'd0; got_nxt = 2'd0; state_nxt = ST_SIFT_RD;
        end
      end
      ST_EMIT_RD: begin
        raddr = emi_r[AW-1:0]; state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        okey_nxt = 32'(rdata_r); olast_nxt = (emi_r + CW'(1) == cnt_r);
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emi_nxt = emi_r + CW'(1);
          if (olast_r) begin
            cnt_nxt = '0; drop_nxt = 1'b0; state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_sorted_key   = okey_r;
  assign out_last_out     = olast_r;
  assign out_keys_dropped = drop_r;
endmodule

FILE: hw/rtl/hse_checker.sv
// Port-level checker for the heap sort engine, with its bind.
module hse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sorted_key,
  input logic        out_last_out
);
  // The engine never loads and emits at once.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("load and emit overlap");
  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_key))
    else $error("result beat changed while stalled");
  // After the final result is taken, loading resumes.
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_out |=> in_ready)
    else $error("no return to loading");
  // Out of reset the engine is ready to load.
  a_rst: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("bad reset state");
endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_sorted_key(out_sorted_key), .out_last_out(out_last_out)
);
